>>> hdl/bucket_histogram_accumulator_top_macros.svh
// Assertion macros shared by the bucket histogram accumulator modules.
// No dependencies; included inside module bodies.
`ifndef BUCKET_HISTOGRAM_ACCUMULATOR_TOP_MACROS_SVH
`define BUCKET_HISTOGRAM_ACCUMULATOR_TOP_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define BHA_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a trigger is followed by a consequence on the next edge.
`define BHA_ASSERT_NEXT(lbl, clk, rst_n, trig, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/bha_pkg.sv
// Shared types and constants for the bucket histogram accumulator.
// No dependencies.
`default_nettype none
package bha_pkg;

    localparam int SAMPLE_W    = 32;
    localparam int IDX_W       = 4;
    localparam int NUM_BOUNDS  = 15;
    localparam int NUM_BUCKETS = 16;
    localparam int COUNT_OUT_W = 32;
    localparam int TOTAL_W     = 48;
    localparam int SUM_W       = 64;
    localparam int QUEUE_DEPTH = 2;

    localparam int IN_DATA_W  = 40;
    localparam int IN_USER_W  = 1;
    localparam int OUT_DATA_W = 216;
    localparam int OUT_USED_W = IDX_W + COUNT_OUT_W + TOTAL_W + SUM_W + 2 * SAMPLE_W;

    localparam logic signed [SAMPLE_W-1:0] BOUNDS [NUM_BOUNDS] = '{
        32'sd0, 32'sd5, 32'sd10, 32'sd25, 32'sd50, 32'sd75, 32'sd100, 32'sd250,
        32'sd500, 32'sd750, 32'sd1000, 32'sd2500, 32'sd5000, 32'sd7500, 32'sd10000
    };

    typedef enum logic {
        REQ_RECORD = 1'b0,
        REQ_READ   = 1'b1
    } t_req;

    typedef struct packed {
        t_req                        req;
        logic signed [SAMPLE_W-1:0]  sample;
        logic [IDX_W-1:0]            idx;
    } t_item;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] largest;
        logic signed [SAMPLE_W-1:0] smallest;
        logic signed [SUM_W-1:0]    running_sum;
        logic [TOTAL_W-1:0]         sample_total;
        logic [COUNT_OUT_W-1:0]     bucket_count;
        logic [IDX_W-1:0]           bucket_index;
    } t_result;

endpackage
`default_nettype wire

>>> hdl/bha_front.sv
// Front end: accepts request beats and classifies samples into buckets.
// Depends on bha_pkg.
`default_nettype none
module bha_front (
    input  wire logic                            i_valid,
    input  wire logic [bha_pkg::IN_DATA_W-1:0]   i_data,
    input  wire logic [bha_pkg::IN_USER_W-1:0]   i_user,
    input  wire logic                            i_full,
    output logic                                 o_ready,
    output logic                                 o_push,
    output bha_pkg::t_item                       o_item
);
    import bha_pkg::*;

    logic signed [SAMPLE_W-1:0] w_sample;
    logic [IDX_W-1:0]           w_read_index;
    logic [NUM_BOUNDS-1:0]      w_above;
    logic [IDX_W-1:0]           w_bucket;
    t_req                       w_req;

    assign w_sample     = i_data[SAMPLE_W-1:0];
    assign w_read_index = i_data[SAMPLE_W +: IDX_W];
    assign w_req        = t_req'(i_user[0]);

    always_comb begin
        for (int i = 0; i < NUM_BOUNDS; i++) begin
            w_above[i] = (w_sample > BOUNDS[i]);
        end
    end

    assign w_bucket = IDX_W'($countones(w_above));

    always_comb begin
        o_item.req    = w_req;
        o_item.sample = w_sample;
        unique case (w_req)
            REQ_RECORD: o_item.idx = w_bucket;
            REQ_READ:   o_item.idx = w_read_index;
            default:    o_item.idx = w_read_index;
        endcase
    end

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;

endmodule
`default_nettype wire

>>> hdl/bha_queue.sv
// Short queue between the classifier and the update stage.
// Depends on bha_pkg and the assertion macro header.
`default_nettype none
module bha_queue (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire bha_pkg::t_item   i_item,
    input  wire logic             i_pop,
    output logic                  o_full,
    output logic                  o_valid,
    output bha_pkg::t_item        o_item
);
    import bha_pkg::*;
    `include "bucket_histogram_accumulator_top_macros.svh"

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_item              r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               w_do_pop;

    assign o_full   = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_valid  = (r_count != '0);
    assign o_item   = r_mem[r_rd_ptr];
    assign w_do_pop = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !w_do_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && w_do_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    `BHA_ASSERT_ALWAYS(a_no_push_full, i_clk, i_rst_n, !(i_push && o_full), "push into full queue")
    `BHA_ASSERT_ALWAYS(a_count_range, i_clk, i_rst_n, (r_count <= CNT_W'(QUEUE_DEPTH)), "queue count out of range")

endmodule
`default_nettype wire

>>> hdl/bha_back.sv
// Back end: updates bucket counts and running statistics, holds the result beat.
// Depends on bha_pkg and the assertion macro header.
`default_nettype none
module bha_back #(
    parameter int BUCKET_COUNT_BITS = 32
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    input  wire bha_pkg::t_item                    i_item,
    output logic                                   o_pop,
    output logic                                   o_valid,
    input  wire logic                              i_ready,
    output logic [bha_pkg::OUT_DATA_W-1:0]         o_data
);
    import bha_pkg::*;
    `include "bucket_histogram_accumulator_top_macros.svh"

    logic [BUCKET_COUNT_BITS-1:0] r_cnt [NUM_BUCKETS];
    logic [BUCKET_COUNT_BITS-1:0] w_cnt_cur, n_cnt;
    logic [TOTAL_W-1:0]           r_total, n_total;
    logic signed [SUM_W-1:0]      r_sum, n_sum, w_sum_add, w_sext;
    logic signed [SAMPLE_W-1:0]   r_min, n_min, r_max, n_max;
    logic                         r_out_valid;
    logic [OUT_DATA_W-1:0]        r_out_data;
    logic                         w_advance;
    logic                         w_record;
    logic                         w_first;
    logic                         w_ovf;
    t_result                      w_res;

    assign w_advance = !r_out_valid || i_ready;
    assign o_pop     = i_valid && w_advance;
    assign w_record  = (i_item.req == REQ_RECORD);
    assign w_first   = (r_total == '0);
    assign w_cnt_cur = r_cnt[i_item.idx];

    assign w_sext    = {{(SUM_W - SAMPLE_W){i_item.sample[SAMPLE_W-1]}}, i_item.sample};
    assign w_sum_add = r_sum + w_sext;
    assign w_ovf     = (r_sum[SUM_W-1] == w_sext[SUM_W-1])
                    && (w_sum_add[SUM_W-1] != r_sum[SUM_W-1]);

    always_comb begin
        n_cnt   = w_cnt_cur;
        n_total = r_total;
        n_sum   = r_sum;
        n_min   = r_min;
        n_max   = r_max;
        unique case (i_item.req)
            REQ_RECORD: begin
                if (w_cnt_cur != '1) begin
                    n_cnt = w_cnt_cur + 1'b1;
                end
                if (r_total != '1) begin
                    n_total = r_total + 1'b1;
                end
                if (w_ovf) begin
                    n_sum = r_sum[SUM_W-1] ? {1'b1, {(SUM_W - 1){1'b0}}}
                                           : {1'b0, {(SUM_W - 1){1'b1}}};
                end else begin
                    n_sum = w_sum_add;
                end
                if (w_first || (i_item.sample < r_min)) begin
                    n_min = i_item.sample;
                end
                if (w_first || (i_item.sample > r_max)) begin
                    n_max = i_item.sample;
                end
            end
            REQ_READ: begin
                n_cnt = w_cnt_cur;
            end
            default: begin
                n_cnt = w_cnt_cur;
            end
        endcase
    end

    always_comb begin
        w_res.bucket_index = i_item.idx;
        w_res.bucket_count = COUNT_OUT_W'(n_cnt);
        w_res.sample_total = n_total;
        w_res.running_sum  = n_sum;
        w_res.smallest     = n_min;
        w_res.largest      = n_max;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_BUCKETS; i++) begin
                r_cnt[i] <= '0;
            end
            r_total     <= '0;
            r_sum       <= '0;
            r_min       <= '0;
            r_max       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop && w_record) begin
                r_cnt[i_item.idx] <= n_cnt;
                r_total           <= n_total;
                r_sum             <= n_sum;
                r_min             <= n_min;
                r_max             <= n_max;
            end
            if (w_advance) begin
                r_out_valid <= i_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out_data <= OUT_DATA_W'(w_res);
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;

    `BHA_ASSERT_NEXT(a_pop_shows, i_clk, i_rst_n, o_pop, r_out_valid, "popped item not presented")
    `BHA_ASSERT_ALWAYS(a_min_le_max, i_clk, i_rst_n, ((r_total == '0) || (r_min <= r_max)), "minimum above maximum")
    `BHA_ASSERT_ALWAYS(a_empty_stats, i_clk, i_rst_n, ((r_total != '0) || ((r_min == '0) && (r_max == '0) && (r_sum == '0))), "statistics set without samples")

endmodule
`default_nettype wire

>>> hdl/bucket_histogram_accumulator_top.sv
// Bucket histogram accumulator, top level.
// An accepted beat is queued, then its result is registered in the back end.
// Throughput: one beat per cycle unless m_axis_tready back-pressure stalls it.
// Reset: synchronous, active low; clears all counts, statistics and queue state.
// Depends on bha_pkg, bha_front, bha_queue and bha_back.
`default_nettype none
module bucket_histogram_accumulator_top #(
    parameter int BUCKET_COUNT_BITS = 32
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // sample[31:0], read_index[35:32], zero fill
    input  wire logic [bha_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // req_type[0]
    input  wire logic [bha_pkg::IN_USER_W-1:0]     s_axis_tuser,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // bucket_index[3:0], bucket_count[35:4], sample_total[83:36],
    // running_sum[147:84], smallest[179:148], largest[211:180], zero fill
    output logic [bha_pkg::OUT_DATA_W-1:0]         m_axis_tdata
);
    import bha_pkg::*;

    logic  w_push;
    logic  w_full;
    logic  w_q_valid;
    logic  w_pop;
    t_item w_front_item;
    t_item w_q_item;

    bha_front u_front (
        .i_valid (s_axis_tvalid),
        .i_data  (s_axis_tdata),
        .i_user  (s_axis_tuser),
        .i_full  (w_full),
        .o_ready (s_axis_tready),
        .o_push  (w_push),
        .o_item  (w_front_item)
    );

    bha_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_front_item),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .o_item  (w_q_item)
    );

    bha_back #(
        .BUCKET_COUNT_BITS (BUCKET_COUNT_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_q_valid),
        .i_item  (w_q_item),
        .o_pop   (w_pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (m_axis_tdata)
    );

endmodule
`default_nettype wire
